[sv/hamu_pkg.sv]
// ----------------------------------------------------------------------------
// hamu_pkg: shared constants for the binary16 add/multiply unit
// Field layout, exponent limits and special bit patterns of IEEE binary16.
// ----------------------------------------------------------------------------
`default_nettype none

package hamu_pkg;

   localparam int unsigned FRAC_BITS = 10;
   localparam int unsigned EXP_BITS  = 5;
   localparam int unsigned HALF_BITS = 16;

   // Exact sum of aligned significands: 11 bits shifted by up to 29, plus carry.
   localparam int unsigned WIDE_BITS = 41;
   localparam int unsigned POS_BITS  = 6;
   localparam int unsigned SCL_BITS  = 8;

   localparam logic [EXP_BITS-1:0]  EXP_MAX  = 5'd31;
   localparam logic [SCL_BITS-1:0]  EXP_BIAS = 8'd15;
   localparam logic [HALF_BITS-1:0] INF_BITS = 16'h7C00;
   localparam logic [HALF_BITS-1:0] NAN_MUL  = 16'hFFFE;

   typedef enum logic {
      ACT_ADD = 1'b0,
      ACT_MUL = 1'b1
   } action_type;

endpackage

`default_nettype wire

[sv/half_add_multiply_unit_core.sv]
// ----------------------------------------------------------------------------
// half_add_multiply_unit_core: binary16 adder and multiplier
// Adds or multiplies two binary16 operands, truncating toward zero.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                                   | tuser
//  req_    | in        | operand_a [15:0], operand_b [31:16]     | action (0 add, 1 mul)
//  rsp_    | out       | result_bits [15:0]                      | -
//
//  One transaction is accepted per cycle while req_tready is high; its result
//  passes the input register, then the result register, before it is
//  presented on rsp_.
//  The arithmetic sits in one combinational pass between the two registers.
//  A stalled result holds each full stage; req_tready falls only when both are full.
//  Reset clears the valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none

module half_add_multiply_unit_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // operand_a [15:0], operand_b [31:16]
   input  wire logic        req_tuser,   // action [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // result_bits [15:0]
);

   localparam int unsigned W  = hamu_pkg::WIDE_BITS;
   localparam int unsigned FB = hamu_pkg::FRAC_BITS;

   logic        s1_valid_ff, s1_valid_in;
   logic        act_ff;
   logic [15:0] a_ff, b_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic        s2_en;
   logic [15:0] res;

   // Packs sign and value m * 2^(q - 25), truncating toward zero.
   function automatic logic [15:0] pack_fn(input logic s, input logic [W-1:0] m,
                                           input logic signed [7:0] q);
      logic [5:0]        p;
      logic signed [7:0] e;
      logic [W-1:0]      t;
      logic [7:0]        sh;
      p = '0;
      for (int i = 0; i < W; i++) begin
         if (m[i]) p = 6'(i);
      end
      e = q + 8'($signed({2'b00, p})) - 8'sd10;
      t = '0;
      if (m == '0) begin
         pack_fn = {s, 15'd0};
      end else if (e >= 8'sd31) begin
         pack_fn = {s, 15'h7C00};
      end else if (e >= 8'sd1) begin
         if (p > 6'(FB)) t = m >> (p - 6'(FB));
         else t = m << (6'(FB) - p);
         pack_fn = {s, e[4:0], t[FB-1:0]};
      end else begin
         if (q < 8'sd1) begin
            sh = 8'(8'sd1 - q);
            t  = (sh >= 8'(W)) ? '0 : (m >> sh);
         end else begin
            t = m << 8'(q - 8'sd1);
         end
         pack_fn = {s, 5'd0, t[FB-1:0]};
      end
   endfunction

   // Datapath between the input register and the result register.
   always_comb begin
      logic [4:0]  ea_f, eb_f;
      logic        sa, sb, s;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
      logic [10:0] siga, sigb;
      logic [4:0]  ea, eb, emin;
      logic [W-1:0] ma, mb;
      logic [21:0] prod;
      ea_f   = a_ff[14:10];
      eb_f   = b_ff[14:10];
      sa     = a_ff[15];
      sb     = b_ff[15];
      s      = sa ^ sb;
      nan_a  = (ea_f == hamu_pkg::EXP_MAX) && (a_ff[9:0] != '0);
      nan_b  = (eb_f == hamu_pkg::EXP_MAX) && (b_ff[9:0] != '0);
      inf_a  = (ea_f == hamu_pkg::EXP_MAX) && (a_ff[9:0] == '0);
      inf_b  = (eb_f == hamu_pkg::EXP_MAX) && (b_ff[9:0] == '0);
      zero_a = (a_ff[14:0] == '0);
      zero_b = (b_ff[14:0] == '0);
      siga   = {(ea_f != '0), a_ff[9:0]};
      sigb   = {(eb_f != '0), b_ff[9:0]};
      ea     = (ea_f != '0) ? ea_f : 5'd1;
      eb     = (eb_f != '0) ? eb_f : 5'd1;
      emin   = (ea < eb) ? ea : eb;
      ma     = W'(siga) << (ea - emin);
      mb     = W'(sigb) << (eb - emin);
      prod   = siga * sigb;
      if (nan_a) begin
         res = a_ff;
      end else if (nan_b) begin
         res = b_ff;
      end else if (act_ff == hamu_pkg::ACT_MUL) begin
         if (inf_a || inf_b) begin
            res = (zero_a || zero_b) ? hamu_pkg::NAN_MUL : {s, 15'h7C00};
         end else begin
            res = pack_fn(s, W'(prod),
                          8'({3'd0, ea}) + 8'({3'd0, eb}) - 8'sd25);
         end
      end else begin
         if (inf_a) begin
            res = (inf_b && (sa != sb)) ? (a_ff | 16'd1) : a_ff;
         end else if (inf_b) begin
            res = b_ff;
         end else if (sa == sb) begin
            res = pack_fn(sa, ma + mb, 8'({3'd0, emin}));
         end else if (ma == mb) begin
            res = '0;
         end else if (ma > mb) begin
            res = pack_fn(sa, ma - mb, 8'({3'd0, emin}));
         end else begin
            res = pack_fn(sb, mb - ma, 8'({3'd0, emin}));
         end
      end
   end

   assign s2_en        = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !s1_valid_ff || s2_en;
   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = s2_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         act_ff <= req_tuser;
         a_ff   <= req_tdata[15:0];
         b_ff   <= req_tdata[31:16];
      end
      if (s2_en && s1_valid_ff) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_en) |=> (rsp_tvalid && rsp_tdata == $past(res)))
      else $error("result stage did not load the computed value");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && s1_valid_ff && !s2_en))
      else $error("input register overwritten while stalled");

endmodule

`default_nettype wire
